/* sv/kpd_pkg.sv */
// Package for the 4x4 keypad scanner: sizes, debounce patterns, key codes
// and the types passed between the row lanes, the event merge and the top level.
// No dependencies.
package kpd_pkg;

    localparam int NUM_ROWS = 4;
    localparam int NUM_COLS = 4;
    localparam int COL_W    = 2;
    localparam int KEY_W    = 4;
    localparam int HIST_W   = 8;
    localparam int EVT_W    = 8;

    // Item kinds carried on the mode input
    localparam logic MODE_SCAN = 1'b0;
    localparam logic MODE_POP  = 1'b1;

    localparam logic [HIST_W-1:0] HIST_PRESS   = 8'h01;
    localparam logic [HIST_W-1:0] HIST_RELEASE = 8'hFE;
    localparam logic [EVT_W-1:0]  PRESS_FLAG   = 8'h80;
    localparam logic [EVT_W-1:0]  NO_EVENT     = 8'h00;

    // ASCII code of each key, by index 4*column + row
    localparam logic [EVT_W-1:0] KEY_CODES [16] = '{
        8'h44, 8'h43, 8'h42, 8'h41,  // D C B A
        8'h23, 8'h39, 8'h36, 8'h33,  // # 9 6 3
        8'h30, 8'h38, 8'h35, 8'h32,  // 0 8 5 2
        8'h2A, 8'h37, 8'h34, 8'h31   // * 7 4 1
    };

    // What one row lane found on a scan tick
    typedef struct packed {
        logic press;
        logic release_hit;
    } kpd_lane_evt_t;

    // One result item as held in the output queue
    typedef struct packed {
        logic [COL_W-1:0]    driven_column;
        logic [NUM_COLS-1:0] column_lines;
        logic [EVT_W-1:0]    key_event;
        logic                event_pending;
    } kpd_result_t;

endpackage

/* sv/kpd_lane.sv */
// One row lane of the keypad scanner: holds the debounce histories of the
// four keys in its row and flags a press or a release edge. Uses kpd_pkg.
module kpd_lane
    import kpd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             scan,
    input  logic [COL_W-1:0] column,
    input  logic             row_bit,
    output kpd_lane_evt_t    evt
);

    logic [HIST_W-1:0] hist_reg [NUM_COLS];
    logic [HIST_W-1:0] hist_next;

    // Shift in the new sample for the key at the driven column
    assign hist_next = {hist_reg[column][HIST_W-2:0], row_bit};

    // Flag the debounce edges
    assign evt.press       = scan && (hist_next == HIST_PRESS);
    assign evt.release_hit = scan && (hist_next == HIST_RELEASE);

    // Hold histories, update the driven column on a scan tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < NUM_COLS; c++)
            begin
                hist_reg[c] <= '0;
            end
        end
        else if (scan)
        begin
            hist_reg[column] <= hist_next;
        end
    end

endmodule

/* sv/kpd_merge.sv */
// Event merge for the keypad scanner: pushes lane events in row order into
// a two-entry overwriting ring and serves pops. Uses kpd_pkg.
module kpd_merge
    import kpd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             scan,
    input  logic             pop,
    input  logic [COL_W-1:0] column,
    input  kpd_lane_evt_t    lane_evt [NUM_ROWS],
    output logic [EVT_W-1:0] key_event,
    output logic             event_pending
);

    logic [EVT_W-1:0] ring_reg [2];
    logic [EVT_W-1:0] ring_next [2];
    logic             wr_reg;
    logic             wr_next;
    logic             rd_reg;
    logic             rd_next;

    // Push lane events in row order, then serve a pop
    always_comb
    begin
        logic [KEY_W-1:0] idx;
        ring_next = ring_reg;
        wr_next   = wr_reg;
        rd_next   = rd_reg;
        key_event = NO_EVENT;
        idx       = '0;
        if (scan)
        begin
            for (int i = 0; i < NUM_ROWS; i++)
            begin
                idx = {column, 2'(i)};
                if (lane_evt[i].press)
                begin
                    ring_next[wr_next] = PRESS_FLAG | KEY_CODES[idx];
                    wr_next            = ~wr_next;
                end
                else if (lane_evt[i].release_hit)
                begin
                    ring_next[wr_next] = KEY_CODES[idx];
                    wr_next            = ~wr_next;
                end
            end
        end
        if (pop && (ring_next[rd_next] != NO_EVENT))
        begin
            key_event          = ring_next[rd_next];
            ring_next[rd_next] = NO_EVENT;
            rd_next            = ~rd_next;
        end
        event_pending = (ring_next[rd_next] != NO_EVENT);
    end

    // Hold ring and slot pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_reg[0] <= NO_EVENT;
            ring_reg[1] <= NO_EVENT;
            wr_reg      <= 1'b0;
            rd_reg      <= 1'b0;
        end
        else
        begin
            ring_reg <= ring_next;
            wr_reg   <= wr_next;
            rd_reg   <= rd_next;
        end
    end

endmodule

/* sv/matrix_keypad_scan_debounce.sv */
// 4x4 keypad scanner with debounce and a two-entry event ring. Each item
// (a scan tick with the row sample, or a pop) gives one result; four row
// lanes update their key histories in parallel and a merge stage pushes the
// resulting events in row order. Results go through a two-entry output queue,
// so a new item is taken every cycle while the queue has room, and the first
// result appears in the cycle after its item.
// Depends on kpd_pkg, kpd_lane and kpd_merge.
module matrix_keypad_scan_debounce
    import kpd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                mode,
    input  logic [3:0]          row_bits,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [COL_W-1:0]    driven_column,
    output logic [NUM_COLS-1:0] column_lines,
    output logic [EVT_W-1:0]    key_event,
    output logic                event_pending
);

    logic             accept;
    logic             scan;
    logic             pop;
    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_next;
    kpd_lane_evt_t    lane_evt [NUM_ROWS];
    logic [EVT_W-1:0] merge_event;
    logic             merge_pending;
    kpd_result_t      result;

    kpd_result_t      q_reg [2];
    logic             q_wr_reg;
    logic             q_rd_reg;
    logic [1:0]       q_cnt_reg;
    logic [1:0]       q_cnt_next;
    logic             q_pop;

    assign accept = in_valid && in_ready;
    assign scan   = accept && (mode == MODE_SCAN);
    assign pop    = accept && (mode == MODE_POP);

    // Advance the column after a scan tick
    assign col_next = scan ? col_reg + 1'b1 : col_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
        end
    end

    // One lane per row
    for (genvar r = 0; r < NUM_ROWS; r++)
    begin : g_lane
        kpd_lane u_lane (
            .clk     (clk),
            .rst_n   (rst_n),
            .scan    (scan),
            .column  (col_reg),
            .row_bit (row_bits[r]),
            .evt     (lane_evt[r])
        );
    end

    kpd_merge u_merge (
        .clk           (clk),
        .rst_n         (rst_n),
        .scan          (scan),
        .pop           (pop),
        .column        (col_reg),
        .lane_evt      (lane_evt),
        .key_event     (merge_event),
        .event_pending (merge_pending)
    );

    // Build the result item
    always_comb
    begin
        result.driven_column = col_next;
        result.column_lines  = ~(NUM_COLS'(1) << col_next);
        result.key_event     = merge_event;
        result.event_pending = merge_pending;
    end

    // Two-entry output queue
    assign in_ready   = (q_cnt_reg != 2'd2);
    assign out_valid  = (q_cnt_reg != 2'd0);
    assign q_pop      = out_valid && out_ready;
    assign q_cnt_next = q_cnt_reg + {1'b0, accept} - {1'b0, q_pop};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_wr_reg  <= 1'b0;
            q_rd_reg  <= 1'b0;
            q_cnt_reg <= '0;
        end
        else
        begin
            if (accept)
            begin
                q_wr_reg <= ~q_wr_reg;
            end
            if (q_pop)
            begin
                q_rd_reg <= ~q_rd_reg;
            end
            q_cnt_reg <= q_cnt_next;
        end
    end

    // Store result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            q_reg[q_wr_reg] <= result;
        end
    end

    assign driven_column = q_reg[q_rd_reg].driven_column;
    assign column_lines  = q_reg[q_rd_reg].column_lines;
    assign key_event     = q_reg[q_rd_reg].key_event;
    assign event_pending = q_reg[q_rd_reg].event_pending;

endmodule
